// File: rtl/core/crs_pkg.sv
// shared types and constants for the cyclic random shuffle block
// no dependencies; imported by crs_ram users, crs_mod and cyclic_random_shuffle_top
package crs_pkg;

   // store geometry
   localparam int DECK_DEPTH = 64;
   localparam int ELEM_W     = 16;
   localparam int ADDR_W     = $clog2(DECK_DEPTH);
   localparam int CNT_W      = ADDR_W + 1;

   // port field widths
   localparam int CMD_W = 2;
   localparam int RND_W = 31;
   localparam int POS_W = 6;
   localparam int CSR_W = 7;

   // deck size after reset, already saturated to the store depth
   localparam int SIZE_RESET     = 64;
   localparam int SIZE_RESET_SAT = (SIZE_RESET > DECK_DEPTH) ? DECK_DEPTH : SIZE_RESET;

   // divider iteration counter
   localparam int DIV_CNT_W = $clog2(RND_W);

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_STEP = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_RDJ,
      ST_WRI,
      ST_WRJ,
      ST_RDK,
      ST_OUT
   } state_type;

   // request into the remainder unit
   typedef struct packed {
      logic              start;
      logic [RND_W-1:0]  dividend;
      logic [ADDR_W-1:0] divisor;
   } div_req_type;

   // answer from the remainder unit
   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] remainder;
   } div_rsp_type;

endpackage

// File: rtl/core/crs_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module crs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/crs_mod.sv
// iterative remainder unit: dividend mod divisor, one dividend bit per cycle
// depends on crs_pkg
module crs_mod (
   input  logic                clock,
   input  logic                reset,
   input  crs_pkg::div_req_type div_req,
   output crs_pkg::div_rsp_type div_rsp
);
   import crs_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RND_W-1:0]     dvd_ff, dvd_in;
   logic [ADDR_W-1:0]    div_ff, div_in;
   logic [ADDR_W-1:0]    rem_ff, rem_in;
   logic [ADDR_W:0]      trial;

   // one restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial   = {rem_ff, dvd_ff[RND_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         div_in  = div_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RND_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = ADDR_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[ADDR_W-1:0];
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(RND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef SYNTHESIS
   // a new start never lands on a division in flight
   assert property (@(posedge clock) disable iff (reset) div_req.start |-> !busy_ff)
      else $error("remainder unit restarted while busy");
   // remainder is always below the divisor when reported
   assert property (@(posedge clock) disable iff (reset) done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");
   // done pulses only at the end of a run
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("done without a division");
`endif

endmodule

// File: rtl/core/cyclic_random_shuffle_top.sv
// cyclic random shuffle top level: command sequencer, store and output register
// depends on crs_pkg, crs_ram and crs_mod
//
// Usage
//   req channel: one command per transfer. Load (cmd 0) writes element_value at the next
//   store position; step (cmd 1) swaps the entry at the step position i with entry
//   i+1+(random_word mod (size-1-i)) and advances i, wrapping after size-2; readout
//   (cmd 2) emits every entry in order on the rsp channel, last_flag on the final one.
//   Step and readout are dropped until the store is fully loaded; extra loads and
//   command 3 are dropped.
//   csr channel: writes deck_size (saturated to 2..64) and restarts loading; write it
//   only while the block is idle.
// Sequence
//   load: written as the transfer is accepted. step: the remainder unit takes one
//   iteration per dividend bit, then the swap reads and writes the store in ST_RDJ,
//   ST_WRI and ST_WRJ. readout: each result is read in ST_RDK and sent in ST_OUT.
// Reset and stalls
//   synchronous reset clears the size to 64, the load count and step position; store
//   contents are undefined until loaded. A stalled rsp receiver holds the readout
//   in place; the block takes new commands while the last result still waits.
module cyclic_random_shuffle_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [crs_pkg::CMD_W-1:0]    req_cmd,
   input  logic [crs_pkg::ELEM_W-1:0]   req_element_value,
   input  logic [crs_pkg::RND_W-1:0]    req_random_word,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [crs_pkg::ELEM_W-1:0]   rsp_element_out,
   output logic [crs_pkg::POS_W-1:0]    rsp_position_out,
   output logic                         rsp_last_flag,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [crs_pkg::CSR_W-1:0]    csr_deck_size
);
   import crs_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  size_ff, size_in;
   logic [CNT_W-1:0]  loaded_ff, loaded_in;
   logic [ADDR_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [ADDR_W-1:0] j_ff, j_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [ELEM_W-1:0] hold_ff, hold_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0] rsp_elem_ff, rsp_elem_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_xfer, csr_xfer;
   logic              deck_full, out_free, k_last;
   logic              is_load, is_step, is_read;
   logic [CNT_W-1:0]  size_m2, i_next_wide, j_wide, span_wide, size_sat;
   logic [31:0]       csr_wide;
   logic [ADDR_W-1:0] i_start, step_next;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [ELEM_W-1:0] ram_wdata, ram_rdata;

   div_req_type       div_req;
   div_rsp_type       div_rsp;

   // handshakes, a csr write takes the idle cycle ahead of a command
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_xfer  = csr_valid && csr_ready;

   // command decode
   always_comb begin
      is_load = 1'b0;
      is_step = 1'b0;
      is_read = 1'b0;
      unique case (req_cmd)
         CMD_LOAD: is_load = 1'b1;
         CMD_STEP: is_step = 1'b1;
         CMD_READ: is_read = 1'b1;
         default: ;
      endcase
   end

   // size saturation for register writes
   always_comb begin
      csr_wide = 32'(csr_deck_size);
      if (csr_wide < 32'd2) begin
         size_sat = CNT_W'(2);
      end else if (csr_wide > 32'(DECK_DEPTH)) begin
         size_sat = CNT_W'(DECK_DEPTH);
      end else begin
         size_sat = CNT_W'(csr_wide);
      end
   end

   // position arithmetic
   assign deck_full   = (loaded_ff >= size_ff);
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign size_m2     = size_ff - CNT_W'(2);
   assign i_start     = ({1'b0, step_ff} > size_m2) ? '0 : step_ff;
   assign span_wide   = size_ff - CNT_W'(1) - {1'b0, i_start};
   assign j_wide      = {1'b0, i_ff} + CNT_W'(1) + {1'b0, div_rsp.remainder};
   assign i_next_wide = {1'b0, i_ff} + CNT_W'(1);
   assign step_next   = (i_next_wide > size_m2) ? '0 : i_next_wide[ADDR_W-1:0];
   assign k_last      = (({1'b0, k_ff} + CNT_W'(1)) == size_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && is_step && deck_full) begin
               state_in = ST_DIV;
            end else if (req_xfer && is_read && deck_full) begin
               state_in = ST_RDK;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_RDJ;
            end
         end
         ST_RDJ: state_in = ST_WRI;
         ST_WRI: state_in = ST_WRJ;
         ST_WRJ: state_in = ST_IDLE;
         ST_RDK: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = k_last ? ST_IDLE : ST_RDK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath next values
   always_comb begin
      size_in      = size_ff;
      loaded_in    = loaded_ff;
      step_in      = step_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_elem_in  = rsp_elem_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = loaded_ff[ADDR_W-1:0];
      ram_wdata    = req_element_value;
      ram_raddr    = i_ff;
      div_req.start    = 1'b0;
      div_req.dividend = req_random_word;
      div_req.divisor  = span_wide[ADDR_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_xfer) begin
               size_in   = size_sat;
               loaded_in = '0;
               step_in   = '0;
            end else if (req_xfer) begin
               if (is_load && !deck_full) begin
                  ram_we    = 1'b1;
                  loaded_in = loaded_ff + CNT_W'(1);
               end
               if (is_step && deck_full) begin
                  i_in          = i_start;
                  div_req.start = 1'b1;
               end
               if (is_read && deck_full) begin
                  k_in = '0;
               end
            end
         end
         ST_DIV: begin
            ram_raddr = i_ff;
            if (div_rsp.done) begin
               j_in = j_wide[ADDR_W-1:0];
            end
         end
         ST_RDJ: begin
            ram_raddr = j_ff;
            hold_in   = ram_rdata;
         end
         ST_WRI: begin
            ram_raddr = j_ff;
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = ram_rdata;
         end
         ST_WRJ: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = hold_ff;
            step_in   = step_next;
         end
         ST_RDK: begin
            ram_raddr = k_ff;
         end
         ST_OUT: begin
            ram_raddr = k_ff;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_elem_in  = ram_rdata;
               rsp_pos_in   = POS_W'(k_ff);
               rsp_last_in  = k_last;
               k_in         = k_ff + ADDR_W'(1);
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         size_ff      <= CNT_W'(SIZE_RESET_SAT);
         loaded_ff    <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         loaded_ff    <= loaded_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      hold_ff     <= hold_in;
      rsp_elem_ff <= rsp_elem_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   // element store
   crs_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (DECK_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // remainder unit for step commands
   crs_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_element_out  = rsp_elem_ff;
   assign rsp_position_out = rsp_pos_ff;
   assign rsp_last_flag    = rsp_last_ff;

`ifndef SYNTHESIS
   // load count never passes the size in use
   assert property (@(posedge clock) disable iff (reset) loaded_ff <= size_ff)
      else $error("load count beyond deck size");
   // step position stays inside 0..size-2
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, step_ff} + CNT_W'(2)) <= size_ff)
      else $error("step position out of range");
   // remainder unit reports only while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset) div_rsp.done |-> (state_ff == ST_DIV))
      else $error("remainder result outside divide state");
   // swap partner lies above i and inside the deck
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRJ) |-> ((j_ff > i_ff) && ({1'b0, j_ff} < size_ff)))
      else $error("swap index out of range");
   // readout only starts on a full store
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDK) |-> deck_full)
      else $error("readout on partial store");
`endif

endmodule

// File: verif/cyclic_random_shuffle_top_tb.sv
// self-checking testbench for cyclic_random_shuffle_top: clocked driver, monitor and
// an in-bench deck predictor that mirrors load, swap step and readout per transfer
// depends on crs_pkg and cyclic_random_shuffle_top
`timescale 1ns / 1ps

module cyclic_random_shuffle_top_tb;
   import crs_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_PCT     = 19;
   localparam int LONG_HOLD    = 600;
   localparam int SETTLE       = 60;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int ITEM_TARGET  = 330;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ELEM_W-1:0] elem;
      logic [RND_W-1:0]  rnd;
   } deck_cmd_type;

   typedef struct packed {
      logic [ELEM_W-1:0] elem;
      logic [POS_W-1:0]  pos;
      logic              last;
   } readout_type;

   // clock, reset and block inputs, all known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd = CMD_LOAD;
   logic [ELEM_W-1:0]   req_element_value = '0;
   logic [RND_W-1:0]    req_random_word = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ELEM_W-1:0]   rsp_element_out;
   logic [POS_W-1:0]    rsp_position_out;
   logic                rsp_last_flag;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CSR_W-1:0]    csr_deck_size = '0;

   // stimulus and expectation stores
   deck_cmd_type cmd_backlog[$];
   readout_type  readout_expected[$];
   deck_cmd_type next_cmd;
   readout_type  head_readout;

   // predictor state
   logic [ELEM_W-1:0] deck_mirror [DECK_DEPTH];
   int unsigned       mirror_step_pos;
   int unsigned       mirror_fill;
   logic [CSR_W-1:0]  mirror_size_reg;

   int idle_pct    = IDLE_PCT;
   int stall_asks  = 0;
   int stall_seen  = 0;
   int hold_left   = 0;
   int error_count = 0;
   int run_cycles  = 0;
   int sent_items  = 0;

   cyclic_random_shuffle_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_element_value (req_element_value),
      .req_random_word   (req_random_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_element_out   (rsp_element_out),
      .rsp_position_out  (rsp_position_out),
      .rsp_last_flag     (rsp_last_flag),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_deck_size     (csr_deck_size)
   );

   always #5 clock = ~clock;

   // size actually used, clamped to the store depth range
   function automatic int unsigned deck_span();
      int unsigned s;
      s = mirror_size_reg;
      if (s < 2) s = 2;
      if (s > DECK_DEPTH) s = DECK_DEPTH;
      return s;
   endfunction

   // advance the deck mirror by one accepted command, queue any readout words
   task automatic shuffle_deck(input deck_cmd_type c);
      int unsigned n, i, span, j, r32, k;
      logic [ELEM_W-1:0] tmp;
      readout_type word;
      n = deck_span();
      if (c.cmd == CMD_LOAD) begin
         if (mirror_fill < n && mirror_fill < DECK_DEPTH) begin
            deck_mirror[mirror_fill] = c.elem;
            mirror_fill++;
         end
      end else if (c.cmd == CMD_STEP) begin
         if (mirror_fill >= n) begin
            i = mirror_step_pos;
            if (i > n - 2) i = 0;
            span = n - 1 - i;
            r32 = c.rnd;
            j = i + 1 + (r32 % span);
            tmp = deck_mirror[i];
            deck_mirror[i] = deck_mirror[j];
            deck_mirror[j] = tmp;
            i++;
            if (i > n - 2) i = 0;
            mirror_step_pos = i;
         end
      end else if (c.cmd == CMD_READ) begin
         if (mirror_fill >= n) begin
            for (k = 0; k < n; k++) begin
               word.elem = deck_mirror[k];
               word.pos  = POS_W'(k);
               word.last = (k + 1 == n);
               readout_expected = {readout_expected, word};
            end
         end
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", run_cycles, what, got, want);
      error_count++;
   endtask

   // request driver: holds a pending transfer, else pulls from the backlog
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            shuffle_deck({req_cmd, req_element_value, req_random_word});
         end
         if (req_valid && !req_ready) begin
            // keep offering the same item
         end else if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            next_cmd = cmd_backlog.pop_front();
            req_valid         <= 1'b1;
            req_cmd           <= next_cmd.cmd;
            req_element_value <= next_cmd.elem;
            req_random_word   <= next_cmd.rnd;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // readout monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (readout_expected.size() == 0) begin
               report_mismatch("unexpected transfer, element", rsp_element_out, 0);
            end else begin
               head_readout = readout_expected.pop_front();
               if (rsp_element_out !== head_readout.elem)
                  report_mismatch("element_out", rsp_element_out, head_readout.elem);
               if (rsp_position_out !== head_readout.pos)
                  report_mismatch("position_out", rsp_position_out, head_readout.pos);
               if (rsp_last_flag !== head_readout.last)
                  report_mismatch("last_flag", rsp_last_flag, head_readout.last);
            end
         end
         // long hold-off on request, otherwise random stalls
         if (stall_seen != stall_asks) begin
            stall_seen <= stall_asks;
            hold_left  <= LONG_HOLD;
            rsp_ready  <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      run_cycles <= run_cycles + 1;
      if (run_cycles >= CYCLE_LIMIT) begin
         $display("[cyclic_random_shuffle_top] ERROR");
         $finish;
      end
   end

   task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [ELEM_W-1:0] elem,
                           input logic [RND_W-1:0] rnd);
      deck_cmd_type c;
      c.cmd  = cmd;
      c.elem = elem;
      c.rnd  = rnd;
      cmd_backlog = {cmd_backlog, c};
      sent_items++;
   endtask

   function automatic logic [RND_W-1:0] pick_rnd();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return RND_W'($urandom);
   endfunction

   // wait until the block has nothing in flight
   task automatic wait_drained();
      while (cmd_backlog.size() > 0 || req_valid || readout_expected.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // deck size write through the csr channel, only while idle
   task automatic write_deck_size(input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_valid     <= 1'b1;
      csr_deck_size <= value;
      do @(posedge clock); while (!csr_ready);
      mirror_size_reg = value;
      mirror_fill     = 0;
      mirror_step_pos = 0;
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // one random phase: mostly a full load followed by steps and readouts
   task automatic random_phase(input int phase_no);
      int unsigned n, k, ops, r, partial;
      logic [CSR_W-1:0] size_val;
      if (phase_no == 0) size_val = 7'd127;
      else if (phase_no == 1) size_val = 7'd0;
      else if (phase_no == 2) size_val = 7'd1;
      else if ($urandom_range(0, 5) == 0) size_val = CSR_W'($urandom_range(33, 127));
      else size_val = CSR_W'($urandom_range(2, 12));
      idle_pct = (phase_no >= 4 && phase_no <= 6) ? 0 : IDLE_PCT;
      write_deck_size(size_val);
      n = deck_span();
      partial = (phase_no > 3 && $urandom_range(0, 7) == 0);
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 7) == 0)
            push_cmd(CMD_W'($urandom_range(1, 3)), ELEM_W'($urandom), pick_rnd());
         if (partial && k == n - 1) break;
         push_cmd(CMD_LOAD, ELEM_W'($urandom), pick_rnd());
      end
      if (partial) begin
         // broken sequence: store never fills, everything after is dropped
         for (k = 0; k < 4; k++)
            push_cmd(CMD_W'($urandom_range(1, 3)), ELEM_W'($urandom), pick_rnd());
         return;
      end
      if (phase_no == 0) begin
         // receiver holds off while several readouts queue up behind the first
         while (cmd_backlog.size() > 0 || req_valid) @(negedge clock);
         stall_asks++;
         for (k = 0; k < 4; k++) begin
            push_cmd(CMD_READ, ELEM_W'($urandom), pick_rnd());
            push_cmd(CMD_STEP, ELEM_W'($urandom), pick_rnd());
         end
      end
      ops = $urandom_range(8, 25);
      for (k = 0; k < ops; k++) begin
         r = $urandom_range(0, 99);
         if (r < 65) begin
            push_cmd(CMD_STEP, ELEM_W'($urandom), pick_rnd());
         end else if (r < 85) begin
            push_cmd(CMD_READ, ELEM_W'($urandom), pick_rnd());
         end else if (r < 93) begin
            push_cmd(CMD_LOAD, ELEM_W'($urandom), pick_rnd());
         end else begin
            push_cmd(CMD_UNUSED, ELEM_W'($urandom), pick_rnd());
         end
      end
   endtask

   // reset, directed corner cases, then random phases
   initial begin
      int phase_no;
      mirror_size_reg = 7'd64;
      mirror_fill     = 0;
      mirror_step_pos = 0;
      phase_no        = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset size 64, store not full: step, readout and unused are dropped
      push_cmd(CMD_READ, 16'h0000, 31'h0);
      push_cmd(CMD_STEP, 16'h0000, '1);
      push_cmd(CMD_UNUSED, '1, '1);
      push_cmd(CMD_LOAD, 16'hFFFF, 31'h0);
      push_cmd(CMD_READ, 16'hFFFF, '1);
      push_cmd(CMD_STEP, 16'hFFFF, 31'h0);
      wait_drained();

      // size write restarts loading; three-entry deck with step wrap
      write_deck_size(7'd3);
      push_cmd(CMD_STEP, 16'h0000, 31'h0);
      push_cmd(CMD_LOAD, 16'h0000, 31'h0);
      push_cmd(CMD_LOAD, 16'hFFFF, '1);
      push_cmd(CMD_READ, 16'h0000, 31'h0);
      push_cmd(CMD_LOAD, 16'hA5A5, 31'h0);
      push_cmd(CMD_LOAD, 16'h1234, 31'h0);
      push_cmd(CMD_READ, 16'h0000, 31'h0);
      push_cmd(CMD_STEP, 16'h0000, 31'h0);
      push_cmd(CMD_STEP, 16'hFFFF, '1);
      push_cmd(CMD_STEP, 16'h5A5A, 31'h2AAAAAAA);
      push_cmd(CMD_READ, '1, '1);
      push_cmd(CMD_UNUSED, 16'h0000, 31'h0);
      push_cmd(CMD_READ, 16'h0000, 31'h0);
      wait_drained();

      // smallest deck
      write_deck_size(7'd2);
      push_cmd(CMD_LOAD, 16'h8001, 31'h0);
      push_cmd(CMD_LOAD, 16'h7FFE, 31'h0);
      push_cmd(CMD_STEP, 16'h0000, '1);
      push_cmd(CMD_READ, 16'h0000, 31'h0);
      wait_drained();

      while (sent_items < ITEM_TARGET) begin
         random_phase(phase_no);
         wait_drained();
         phase_no++;
      end

      if (error_count == 0) begin
         $display("[cyclic_random_shuffle_top] OK");
      end else begin
         $display("[cyclic_random_shuffle_top] ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/crs_pkg.sv
rtl/core/crs_ram.sv
rtl/core/crs_mod.sv
rtl/core/cyclic_random_shuffle_top.sv
verif/cyclic_random_shuffle_top_tb.sv
